FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the remote pulse encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property while out of reset
`define RPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define RPE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rpe_pkg.sv
// ----------------------------------------------------------------------------
// rpe_pkg
// Types and constants shared by the remote pulse encoder modules.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int ID_BITS     = 16;
  localparam int KEY_BITS    = 7;
  localparam int TIME_BITS   = 10;
  localparam int TOTAL_BITS  = ID_BITS + KEY_BITS;
  localparam int BIT_IDX_W   = $clog2(TOTAL_BITS + 1);
  localparam int SHIFT_IDX_W = (TOTAL_BITS > 1) ? $clog2(TOTAL_BITS) : 1;
  localparam int REPEAT_W    = 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = TIME_BITS;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 3'd4;

  localparam logic [TIME_BITS-1:0] RST_SHORT_TICKS  = TIME_BITS'(170);
  localparam logic [TIME_BITS-1:0] RST_LONG_TICKS   = TIME_BITS'(340);
  localparam logic [TIME_BITS-1:0] RST_START_TICKS  = TIME_BITS'(595);
  localparam logic [REPEAT_W-1:0]  RST_REPEAT_COUNT = REPEAT_W'(50);

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] short_ticks;
    logic [TIME_BITS-1:0] long_ticks;
    logic [TIME_BITS-1:0] start_ticks;
    logic [REPEAT_W-1:0]  repeat_count;
    logic                 invert_output;
  } cfg_t;

  typedef struct packed {
    logic                  is_start;
    logic [TOTAL_BITS-1:0] word;
  } cmd_t;

  function automatic logic [TIME_BITS-1:0] time_of(input logic [TIME_BITS-1:0] t);
    time_of = (t == '0) ? TIME_BITS'(1) : t;
  endfunction

endpackage

FILE: rtl/rpe_cfg.sv
// ----------------------------------------------------------------------------
// rpe_cfg
// Configuration register file for the remote pulse encoder.
// ----------------------------------------------------------------------------
module rpe_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpe_pkg::CFG_DATA_W-1:0] cfg_data,
  output rpe_pkg::cfg_t                  cfg
);
  import rpe_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks   <= RST_SHORT_TICKS;
      cfg_r.long_ticks    <= RST_LONG_TICKS;
      cfg_r.start_ticks   <= RST_START_TICKS;
      cfg_r.repeat_count  <= RST_REPEAT_COUNT;
      cfg_r.invert_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHORT_TICKS:   cfg_r.short_ticks   <= cfg_data[TIME_BITS-1:0];
        REG_LONG_TICKS:    cfg_r.long_ticks    <= cfg_data[TIME_BITS-1:0];
        REG_START_TICKS:   cfg_r.start_ticks   <= cfg_data[TIME_BITS-1:0];
        REG_REPEAT_COUNT:  cfg_r.repeat_count  <= cfg_data[REPEAT_W-1:0];
        REG_INVERT_OUTPUT: cfg_r.invert_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/rpe_front.sv
// ----------------------------------------------------------------------------
// rpe_front
// Accepts requests, classifies them as start or tick and queues them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpe_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [rpe_pkg::ID_BITS-1:0]  in_remote_id,
  input  logic [rpe_pkg::KEY_BITS-1:0] in_key_code,
  output logic                         q_valid,
  input  logic                         q_pop,
  output rpe_pkg::cmd_t                q_cmd
);
  import rpe_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign in_stall = (count_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_valid && q_pop;
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    cmd_in.is_start = (in_func == FUNC_START);
    cmd_in.word     = {in_remote_id, in_key_code};
    count_nxt       = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `RPE_ASSERT(a_count_bound, count_r <= QCNT_W'(QDEPTH), "queue count overflow")
  `RPE_ASSERT(a_ptr_gap, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r), "empty queue ptr mismatch")

endmodule

FILE: rtl/rpe_back.sv
// ----------------------------------------------------------------------------
// rpe_back
// Pulse sequencer: runs frames and bits, drives the registered result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rpe_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  rpe_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_pin_level,
  output logic          out_busy_res,
  output logic          out_done_res
);
  import rpe_pkg::*;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO_A = 2'd1;
  localparam logic [1:0] PH_ZERO_B = 2'd2;
  localparam logic [1:0] PH_ONE    = 2'd3;

  logic [TOTAL_BITS-1:0] id_shift_r,      id_shift_nxt;
  logic [BIT_IDX_W-1:0]  bit_index_r,     bit_index_nxt;
  logic [REPEAT_W-1:0]   frames_left_r,   frames_left_nxt;
  logic [1:0]            phase_r,         phase_nxt;
  logic                  polarity_r,      polarity_nxt;
  logic [TIME_BITS-1:0]  duration_left_r, duration_left_nxt;
  logic                  level_now_r,     level_now_nxt;
  logic                  active_r,        active_nxt;

  logic                  out_valid_r;
  logic                  out_pin_r;
  logic                  out_busy_r;
  logic                  out_done_r;

  logic                  res_pin;
  logic                  res_busy;
  logic                  res_done;
  logic                  advance;
  logic [TIME_BITS-1:0]  dur_dec;
  logic [BIT_IDX_W-1:0]  bit_next;
  logic [BIT_IDX_W-1:0]  shift_pos;
  logic                  bit_val;

  assign advance       = q_valid && (!out_valid_r || !out_stall);
  assign q_pop         = advance;
  assign out_valid     = out_valid_r;
  assign out_pin_level = out_pin_r;
  assign out_busy_res  = out_busy_r;
  assign out_done_res  = out_done_r;

  always_comb begin
    id_shift_nxt      = id_shift_r;
    bit_index_nxt     = bit_index_r;
    frames_left_nxt   = frames_left_r;
    phase_nxt         = phase_r;
    polarity_nxt      = polarity_r;
    duration_left_nxt = duration_left_r;
    level_now_nxt     = level_now_r;
    active_nxt        = active_r;
    res_pin           = 1'b0;
    res_busy          = 1'b0;
    res_done          = 1'b0;
    dur_dec           = (duration_left_r != '0) ? duration_left_r - 1'b1 : '0;
    bit_next          = bit_index_r + BIT_IDX_W'(phase_r != PH_START);
    shift_pos         = BIT_IDX_W'(TOTAL_BITS - 1) - bit_next;
    bit_val           = id_shift_r[shift_pos[SHIFT_IDX_W-1:0]];

    if (q_cmd.is_start) begin
      res_busy = 1'b1;
      if (!active_r) begin
        id_shift_nxt      = q_cmd.word;
        frames_left_nxt   = cfg.repeat_count;
        active_nxt        = 1'b1;
        polarity_nxt      = ~cfg.invert_output;
        phase_nxt         = PH_START;
        bit_index_nxt     = '0;
        level_now_nxt     = ~cfg.invert_output;
        duration_left_nxt = time_of(cfg.start_ticks);
        res_pin           = ~cfg.invert_output;
      end else begin
        res_pin = level_now_r;
      end
    end else if (active_r) begin
      res_pin  = level_now_r;
      res_busy = 1'b1;
      if (dur_dec != '0) begin
        duration_left_nxt = dur_dec;
      end else begin
        unique case (phase_r)
          PH_ZERO_A: begin
            phase_nxt         = PH_ZERO_B;
            level_now_nxt     = polarity_r;
            duration_left_nxt = time_of(cfg.short_ticks);
          end
          default: begin
            bit_index_nxt = bit_next;
            if (bit_next >= BIT_IDX_W'(TOTAL_BITS)) begin
              if (frames_left_r != '0) begin
                frames_left_nxt   = frames_left_r - 1'b1;
                polarity_nxt      = ~cfg.invert_output;
                phase_nxt         = PH_START;
                bit_index_nxt     = '0;
                level_now_nxt     = ~cfg.invert_output;
                duration_left_nxt = time_of(cfg.start_ticks);
              end else begin
                active_nxt        = 1'b0;
                level_now_nxt     = 1'b0;
                phase_nxt         = PH_START;
                duration_left_nxt = '0;
                res_done          = 1'b1;
              end
            end else begin
              level_now_nxt = ~polarity_r;
              if (bit_val) begin
                phase_nxt         = PH_ONE;
                duration_left_nxt = time_of(cfg.long_ticks);
                polarity_nxt      = ~polarity_r;
              end else begin
                phase_nxt         = PH_ZERO_A;
                duration_left_nxt = time_of(cfg.short_ticks);
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_shift_r      <= '0;
      bit_index_r     <= '0;
      frames_left_r   <= '0;
      phase_r         <= PH_START;
      polarity_r      <= 1'b0;
      duration_left_r <= '0;
      level_now_r     <= 1'b0;
      active_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (advance) begin
        id_shift_r      <= id_shift_nxt;
        bit_index_r     <= bit_index_nxt;
        frames_left_r   <= frames_left_nxt;
        phase_r         <= phase_nxt;
        polarity_r      <= polarity_nxt;
        duration_left_r <= duration_left_nxt;
        level_now_r     <= level_now_nxt;
        active_r        <= active_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pin_r  <= res_pin;
      out_busy_r <= res_busy;
      out_done_r <= res_done;
    end
  end

  `RPE_ASSERT(a_idle_pin_low, !active_r |-> !level_now_r, "pin high while idle")
  `RPE_ASSERT(a_active_dur, active_r |-> (duration_left_r != '0), "active with no time left")
  `RPE_ASSERT(a_done_idle, (out_valid_r && out_done_r) |-> !active_r, "done while still active")
  `RPE_ASSERT(a_phase_shape, (active_r && (phase_r == PH_START)) |-> (bit_index_r == '0),
              "start pulse off frame head")

endmodule

FILE: rtl/rf_remote_pulse_encoder_unit.sv
// ----------------------------------------------------------------------------
// rf_remote_pulse_encoder_unit
// Radio remote pulse encoder: turns start and tick requests into pin levels.
// ----------------------------------------------------------------------------
// Each request yields one result. A start request (func 1) loads remote_id
// and key_code and begins repeat_count+1 frames; it is ignored while busy.
// Each tick request (func 0) is one microsecond and returns the pin level for
// it, the busy flag, and done on the tick that ends the last pulse. One
// request is taken per clock sustained while out_stall is low; a request's
// result passes through the two-entry request queue and then the
// sequencer's output register. Write configuration only while idle.
module rf_remote_pulse_encoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [rpe_pkg::ID_BITS-1:0]    in_remote_id,
  input  logic [rpe_pkg::KEY_BITS-1:0]   in_key_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_pin_level,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpe_pkg::*;

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  rpe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_remote_id (in_remote_id),
    .in_key_code  (in_key_code),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_cmd        (q_cmd)
  );

  rpe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pin_level (out_pin_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res)
  );

endmodule
